[sv/pfd_pkg.sv]
package pfd_pkg;

  // item kinds carried on tuser
  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_KEY_END = 2'd1,
    KIND_MSG     = 2'd2,
    KIND_MSG_END = 2'd3
  } kind_e;

  localparam int unsigned ALPHABET = 26;
  localparam int unsigned CELLS    = 25;

  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LETTER_Q    = 5'd16;
  localparam logic [4:0] LETTER_X    = 5'd23;
  localparam logic [4:0] LETTER_LAST = 5'd25;
  localparam logic [4:0] CELL_COUNT  = 5'd25;
  localparam logic [2:0] SIDE_LAST   = 3'd4;

  // used set after reset: only J
  localparam logic [ALPHABET-1:0] USED_RESET = 26'h0000200;

  typedef struct packed {
    logic key_letter;  // place key letter (restart if square is ready)
    logic fill_start;  // clear alphabet scan
    logic fill_step;   // place scan letter if unused, advance scan
    logic pend_load;   // hold first letter of a digraph
    logic pair_msg;    // start digraph from pending + message letter
    logic pair_end;    // start digraph from pending + filler X
    logic cell_load;   // read square into output register
  } pfd_cmd_t;

  typedef struct packed {
    logic sq_ready;
    logic pend_valid;
    logic scan_last;
    logic out_busy;
  } pfd_status_t;

  // (v + 1) mod 5 for a row or column
  function automatic logic [2:0] next_mod5(input logic [2:0] v);
    logic [2:0] r;
    r = (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
    return r;
  endfunction

  // row * 5 + column
  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    logic [4:0] r;
    r = {row, 2'b00} + {2'b00, row} + {2'b00, col};
    return r;
  endfunction

endpackage

[sv/pfd_ctrl.sv]
module pfd_ctrl
  import pfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  kind_e       kind_i,
  input  logic [4:0]  letter_i,
  input  pfd_status_t status_i,
  output pfd_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_CELL = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   letter_ok;
  logic   take;

  assign letter_ok = (letter_i <= LETTER_LAST);
  assign s_ready_o = (state_q == ST_IDLE);
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (kind_i)
            KIND_KEY: begin
              cmd_o.key_letter = letter_ok;
            end
            KIND_KEY_END: begin
              if (!status_i.sq_ready) begin
                cmd_o.fill_start = 1'b1;
                state_d          = ST_FILL;
              end
            end
            KIND_MSG: begin
              if (status_i.sq_ready && letter_ok) begin
                if (status_i.pend_valid) begin
                  cmd_o.pair_msg = 1'b1;
                  state_d        = ST_CELL;
                end else begin
                  cmd_o.pend_load = 1'b1;
                end
              end
            end
            default: begin
              if (status_i.sq_ready && status_i.pend_valid) begin
                cmd_o.pair_end = 1'b1;
                state_d        = ST_CELL;
              end
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CELL: begin
        if (!status_i.out_busy) begin
          cmd_o.cell_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/pfd_datapath.sv]
module pfd_datapath
  import pfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  letter_i,
  input  pfd_cmd_t    cmd_i,
  output pfd_status_t status_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [4:0]  cipher_first_o,
  output logic [4:0]  cipher_second_o
);

  // key square and letter position table
  logic [4:0] sq_mem  [CELLS];
  logic [5:0] pos_mem [ALPHABET];

  logic [ALPHABET-1:0] used_q, used_d, used_base;
  logic [4:0] fill_q, fill_d, fill_base;
  logic [2:0] row_q, row_d, row_base;
  logic [2:0] col_q, col_d, col_base;
  logic       ready_q, ready_d;
  logic       pend_valid_q, pend_valid_d;
  logic [4:0] pend_letter_q;
  logic [4:0] scan_q;
  logic       out_valid_q;
  logic [4:0] cipher_first_q, cipher_second_q;

  logic       restart;
  logic [4:0] place_letter;
  logic       place_en;
  logic       doubled;
  logic       pair;
  logic [4:0] pair_a, pair_b;

  logic [5:0] pos_a_q, pos_b_q;
  logic       a_is_j_q, b_is_j_q;
  logic [5:0] pos_a, pos_b;
  logic [2:0] r1, c1, r2, c2;
  logic [4:0] idx1, idx2;

  // placement: key letters and the key-end alphabet walk
  always_comb begin
    restart      = cmd_i.key_letter && ready_q;
    used_base    = restart ? USED_RESET : used_q;
    fill_base    = restart ? 5'd0 : fill_q;
    row_base     = restart ? 3'd0 : row_q;
    col_base     = restart ? 3'd0 : col_q;
    place_letter = cmd_i.fill_step ? scan_q : letter_i;
    place_en     = (cmd_i.key_letter || cmd_i.fill_step) && !used_base[place_letter]
                   && (fill_base < CELL_COUNT);

    used_d = used_q;
    fill_d = fill_q;
    row_d  = row_q;
    col_d  = col_q;
    if (cmd_i.key_letter || cmd_i.fill_step) begin
      used_d = used_base;
      fill_d = fill_base;
      row_d  = row_base;
      col_d  = col_base;
      if (place_en) begin
        used_d[place_letter] = 1'b1;
        fill_d = fill_base + 5'd1;
        if (col_base == SIDE_LAST) begin
          col_d = 3'd0;
          row_d = row_base + 3'd1;
        end else begin
          col_d = col_base + 3'd1;
        end
      end
    end
  end

  // digraph operands
  always_comb begin
    doubled = (pend_letter_q == letter_i);
    pair    = cmd_i.pair_msg || cmd_i.pair_end;
    pair_a  = pend_letter_q;
    if (cmd_i.pair_end) begin
      pair_b = LETTER_X;
    end else if (doubled) begin
      pair_b = (letter_i == LETTER_X) ? LETTER_Q : LETTER_X;
    end else begin
      pair_b = letter_i;
    end
  end

  always_comb begin
    ready_d = ready_q;
    if (restart) begin
      ready_d = 1'b0;
    end else if (cmd_i.fill_step && (scan_q == LETTER_LAST)) begin
      ready_d = 1'b1;
    end

    pend_valid_d = pend_valid_q;
    if (restart || cmd_i.pair_end) begin
      pend_valid_d = 1'b0;
    end else if (cmd_i.pend_load) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.pair_msg) begin
      pend_valid_d = doubled;  // doubled letter carries over
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= USED_RESET;
      fill_q       <= 5'd0;
      row_q        <= 3'd0;
      col_q        <= 3'd0;
      ready_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      scan_q       <= 5'd0;
      out_valid_q  <= 1'b0;
    end else begin
      used_q       <= used_d;
      fill_q       <= fill_d;
      row_q        <= row_d;
      col_q        <= col_d;
      ready_q      <= ready_d;
      pend_valid_q <= pend_valid_d;
      if (cmd_i.fill_start) begin
        scan_q <= 5'd0;
      end else if (cmd_i.fill_step) begin
        scan_q <= scan_q + 5'd1;
      end
      if (cmd_i.cell_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_letter_q <= letter_i;
    end
  end

  // position table: one write port, two registered reads
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      pos_mem[place_letter] <= {row_base, col_base};
    end
    if (pair) begin
      pos_a_q  <= pos_mem[pair_a];
      pos_b_q  <= pos_mem[pair_b];
      a_is_j_q <= (pair_a == LETTER_J);
      b_is_j_q <= (pair_b == LETTER_J);
    end
  end

  // J is never placed and sits at row 0, column 0
  always_comb begin
    pos_a = a_is_j_q ? 6'd0 : pos_a_q;
    pos_b = b_is_j_q ? 6'd0 : pos_b_q;
    r1 = pos_a[5:3];
    c1 = pos_a[2:0];
    r2 = pos_b[5:3];
    c2 = pos_b[2:0];
    if (r1 == r2) begin
      idx1 = cell_index(r1, next_mod5(c1));
      idx2 = cell_index(r2, next_mod5(c2));
    end else if (c1 == c2) begin
      idx1 = cell_index(next_mod5(r1), c1);
      idx2 = cell_index(next_mod5(r2), c2);
    end else begin
      idx1 = cell_index(r1, c2);
      idx2 = cell_index(r2, c1);
    end
  end

  // key square: one write port, two reads straight into the output register
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[fill_base] <= place_letter;
    end
    if (cmd_i.cell_load) begin
      cipher_first_q  <= sq_mem[idx1];
      cipher_second_q <= sq_mem[idx2];
    end
  end

  assign status_o.sq_ready   = ready_q;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.scan_last  = (scan_q == LETTER_LAST);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign cipher_first_o  = cipher_first_q;
  assign cipher_second_o = cipher_second_q;

endmodule

[sv/playfair_digraph_encryptor.sv]
// Playfair digraph encryptor. Feed the key as key-letter items (tuser 0), then
// one key-end item (tuser 1), then the message as message-letter items (tuser 2)
// and a message-end item (tuser 3); letters are 0 = A .. 25 = Z in tdata.
// Key letters fill the 5x5 square in order of first appearance; J and repeats
// are dropped. Key end fills the free cells with the unused letters A..Z (no J).
// Message letters pair up; a doubled letter is split with X (Q when it is X)
// and the second one carries into the next pair; message end pads a lone letter
// with X. Each digraph gives one transfer on the master side. A key letter
// after the square is complete wipes it and starts a new key. Message items
// before the square is complete, and letter codes above 25, are dropped.
// Order: a key letter, an unpaired message letter and any dropped item are
// handled while idle. A completed digraph first reads the position table (two
// read ports) into registers, then reads the key square (two read ports) into
// the output register. Key end walks the alphabet, taking one letter per
// cycle and placing it if it is unused. A finished digraph waits in the output
// register while further items are taken; only the next digraph's square read
// waits for that register to drain.
module playfair_digraph_encryptor
  import pfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [4:0] cipher_first, [9:5] cipher_second, [15:10] zero
);

  pfd_cmd_t    cmd;
  pfd_status_t status;
  logic [4:0]  cipher_first;
  logic [4:0]  cipher_second;

  pfd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .kind_i    (kind_e'(s_axis_tuser)),
    .letter_i  (s_axis_tdata[4:0]),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pfd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .letter_i        (s_axis_tdata[4:0]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .cipher_first_o  (cipher_first),
    .cipher_second_o (cipher_second)
  );

  assign m_axis_tdata = {6'd0, cipher_second, cipher_first};

  // square read never overwrites a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cell_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before transfer");

  // a pending letter only exists once the square is complete
  a_pend_needs_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pend_valid |-> status.sq_ready)
    else $error("pending letter without complete square");

  // a started digraph blocks input until its square read
  a_pair_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pair_msg || cmd.pair_end) |=> !s_axis_tready)
    else $error("input taken during digraph lookup");

  // a key letter on a complete square starts a new key
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.key_letter && status.sq_ready) |=> (!status.sq_ready && !status.pend_valid))
    else $error("key restart did not clear square state");

endmodule

[tb/sv/pfd_cipher_checker.sv]
`timescale 1ns / 1ps

// Watches both stream channels, keeps its own copy of the key square and
// pairing state, and compares every digraph transfer against the oldest
// predicted one.
module pfd_cipher_checker
  import pfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [4:0] cipher_first, [9:5] cipher_second, [15:10] zero
  output int unsigned errors_o,
  output int unsigned cipher_due_o
);

  typedef struct packed {
    logic [4:0] second;
    logic [4:0] first;
  } digraph_t;

  logic [4:0]          key_cell [CELLS];
  logic [2:0]          cell_row [ALPHABET];
  logic [2:0]          cell_col [ALPHABET];
  logic [ALPHABET-1:0] seen_set;
  int unsigned         placed;
  logic                key_done;
  logic                held_valid;
  logic [4:0]          held_letter;
  digraph_t            cipher_q [$];
  int unsigned         mismatches;

  // back to the empty key: only J counts as taken
  function automatic void wipe_square();
    for (int i = 0; i < CELLS; i++) key_cell[i] = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      cell_row[i] = '0;
      cell_col[i] = '0;
    end
    seen_set    = USED_RESET;
    placed      = 0;
    key_done    = 1'b0;
    held_valid  = 1'b0;
    held_letter = '0;
  endfunction

  function automatic void place_letter(input logic [4:0] l);
    if (placed < CELLS) begin
      key_cell[placed] = l;
      cell_row[l]      = 3'(placed / 5);
      cell_col[l]      = 3'(placed % 5);
      seen_set[l]      = 1'b1;
      placed++;
    end
  endfunction

  // row rule, then column rule, then rectangle
  function automatic digraph_t encipher(input logic [4:0] a, input logic [4:0] b);
    logic [2:0]  r1, c1, r2, c2;
    int unsigned i1, i2;
    digraph_t    d;
    r1 = cell_row[a];
    c1 = cell_col[a];
    r2 = cell_row[b];
    c2 = cell_col[b];
    if (r1 == r2) begin
      i1 = r1 * 5 + (c1 + 1) % 5;
      i2 = r2 * 5 + (c2 + 1) % 5;
    end else if (c1 == c2) begin
      i1 = ((r1 + 1) % 5) * 5 + c1;
      i2 = ((r2 + 1) % 5) * 5 + c2;
    end else begin
      i1 = r1 * 5 + c2;
      i2 = r2 * 5 + c1;
    end
    d.first  = key_cell[i1 % CELLS];
    d.second = key_cell[i2 % CELLS];
    return d;
  endfunction

  function automatic void take_item(input kind_e k, input logic [4:0] l);
    case (k)
      KIND_KEY: begin
        if (l <= LETTER_LAST) begin
          // a key letter after a finished square starts a new key
          if (key_done) wipe_square();
          if (!seen_set[l]) place_letter(l);
        end
      end
      KIND_KEY_END: begin
        for (int x = 0; x < ALPHABET; x++)
          if (!seen_set[x] && placed < CELLS) place_letter(5'(x));
        key_done = 1'b1;
      end
      KIND_MSG: begin
        if (key_done && l <= LETTER_LAST) begin
          if (!held_valid) begin
            held_letter = l;
            held_valid  = 1'b1;
          end else if (held_letter == l) begin
            // doubled letter: split with filler, second one carries over
            cipher_q = {cipher_q, encipher(l, (l == LETTER_X) ? LETTER_Q : LETTER_X)};
          end else begin
            cipher_q   = {cipher_q, encipher(held_letter, l)};
            held_valid = 1'b0;
          end
        end
      end
      default: begin
        if (key_done && held_valid) begin
          cipher_q   = {cipher_q, encipher(held_letter, LETTER_X)};
          held_valid = 1'b0;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digraph_t want;
    if (!rst_ni) begin
      wipe_square();
      cipher_q.delete();
      mismatches = 0;
    end else begin
      // output first: a transfer here always belongs to an older item
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected digraph: got first %0d second %0d",
                     m_axis_tdata[4:0], m_axis_tdata[9:5]);
        end else begin
          want = cipher_q.pop_front();
          if (m_axis_tdata[4:0] !== want.first || m_axis_tdata[9:5] !== want.second) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digraph mismatch: expected first %0d second %0d, got %0d %0d",
                       want.first, want.second, m_axis_tdata[4:0], m_axis_tdata[9:5]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        take_item(kind_e'(s_axis_tuser), s_axis_tdata[4:0]);
    end
    cipher_due_o <= cipher_q.size();
  end

  assign errors_o = mismatches;

endmodule

[tb/sv/playfair_digraph_encryptor_test.sv]
`timescale 1ns / 1ps

module playfair_digraph_encryptor_test;
  import pfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_AT       = 30;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  int unsigned errors;
  int unsigned cipher_due;
  int unsigned digraphs_taken;
  int unsigned items_sent;
  logic        tx_idle;
  logic        rx_idle;
  logic        rx_hold;

  playfair_digraph_encryptor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pfd_cipher_checker cipher_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .cipher_due_o  (cipher_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // one input transfer; gaps are skipped while the receiver is held off
  task automatic send(input kind_e k, input logic [4:0] l);
    int unsigned gap;
    gap = (tx_idle && !rx_hold) ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {3'b000, l};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering until every predicted digraph has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (cipher_due != 0) @(posedge clk_i);
  endtask

  // mostly real letters, now and then an out-of-range code
  function automatic logic [4:0] pick_letter();
    logic [4:0] l;
    if ($urandom_range(0, 15) == 0) l = 5'($urandom_range(26, 31));
    else l = 5'($urandom_range(0, 25));
    return l;
  endfunction

  // optional noise, then usually a key + key end, then a message with doubles and fillers
  task automatic run_sequence();
    int unsigned n;
    logic [4:0]  prev;
    logic [4:0]  l;
    tx_idle = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) send(kind_e'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
    end
    if ($urandom_range(0, 4) != 0) begin
      n = $urandom_range(0, 12);
      repeat (n) send(KIND_KEY, pick_letter());
      send(KIND_KEY_END, 5'($urandom_range(0, 31)));
      items_sent += n + 1;
    end
    n    = $urandom_range(1, 24);
    prev = LETTER_X;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: l = prev;
        2: l = LETTER_J;
        3: l = LETTER_X;
        default: l = pick_letter();
      endcase
      send(KIND_MSG, l);
      prev = l;
    end
    items_sent += n;
    if ($urandom_range(0, 3) != 0) begin
      send(KIND_MSG_END, 5'($urandom_range(0, 31)));
      items_sent++;
    end
    if ($urandom_range(0, 11) == 0) drain();
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_KEY;
    tx_idle    = 1'b1;
    items_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // message items before any key are dropped
    send(KIND_MSG, 5'd5);
    send(KIND_MSG_END, 5'd0);
    // key "PLA" with a J, a repeat and two bad codes mixed in
    send(KIND_KEY, 5'd15);
    send(KIND_KEY, 5'd11);
    send(KIND_KEY, 5'd0);
    send(KIND_KEY, LETTER_J);
    send(KIND_KEY, 5'd11);
    send(KIND_KEY, 5'd31);
    send(KIND_KEY, 5'd26);
    send(KIND_KEY_END, 5'd0);
    send(KIND_KEY_END, 5'd31);         // square already complete
    send(KIND_MSG_END, 5'd0);          // nothing held
    // J sits on the cell of P: same cell, row rule
    send(KIND_MSG, LETTER_J);
    send(KIND_MSG, 5'd15);
    // doubled L split with X, second L carries into the next pair
    send(KIND_MSG, 5'd11);
    send(KIND_MSG, 5'd11);
    send(KIND_MSG, 5'd0);
    // doubled X split with Q, lone X padded to XX
    send(KIND_MSG, LETTER_X);
    send(KIND_MSG, LETTER_X);
    send(KIND_MSG_END, 5'd0);
    send(KIND_MSG, 5'd30);
    send(KIND_MSG, 5'd25);
    send(KIND_MSG_END, 5'd0);
    // key letter after a finished square restarts the key
    send(KIND_KEY, 5'd25);
    send(KIND_KEY_END, 5'd0);
    drain();

    while (items_sent < RANDOM_ITEMS) run_sequence();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // output side: random hold-off per transfer, idle-free stretches, and one
  // long hold that backs the block up into its input
  initial begin : receiver
    int unsigned stall;
    m_axis_tready <= 1'b0;
    rx_idle        = 1'b1;
    rx_hold        = 1'b0;
    digraphs_taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 24) == 0) rx_idle = !rx_idle;
      stall = rx_idle ? $urandom_range(0, 14) : 0;
      if (digraphs_taken == HOLD_AT) begin
        rx_hold = 1'b1;
        stall   = HOLD_CYCLES;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rx_hold = 1'b0;
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      digraphs_taken++;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
